@@ design/i2cmb_pkg.sv @@
package i2cmb_pkg;

    // Depths of the two word queues around the sequencer.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Register reset value: ticks per hold unit.
    localparam logic [15:0] UNIT_TICKS_RESET = 16'd125;

    // Bit counts that close the byte loop and the bus clear loop.
    localparam logic [3:0] BYTE_BITS  = 4'd8;
    localparam logic [3:0] CLEAR_CLKS = 4'd9;

    // Command codes on the action field.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4,
        ACT_CLEAR = 3'd5
    } t_act;

    // Sequencer phases, one-hot.
    typedef enum logic [10:0] {
        PH_IDLE  = 11'b000_0000_0001,
        PH_START = 11'b000_0000_0010,
        PH_STOP  = 11'b000_0000_0100,
        PH_WBIT  = 11'b000_0000_1000,
        PH_WACK  = 11'b000_0001_0000,
        PH_RBIT  = 11'b000_0010_0000,
        PH_RACK  = 11'b000_0100_0000,
        PH_CLK9  = 11'b000_1000_0000,
        PH_CLRSS = 11'b001_0000_0000,
        PH_FIN   = 11'b010_0000_0000,
        PH_FIN0  = 11'b100_0000_0000
    } t_phase;

    // One classified input word.
    typedef struct packed {
        t_act       act;
        logic [7:0] write_data;
        logic       send_nack;
        logic       sda_in;
    } t_item;

    // One result word.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } t_result;

endpackage

@@ design/i2cmb_queue.sv @@
module i2cmb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill count update, with wrap at the last entry.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/i2cmb_front.sv @@
module i2cmb_front
    import i2cmb_pkg::*;
#(
    parameter int MID_Q_DEPTH = MID_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_action,
    input  logic [7:0] i_write_data,
    input  logic       i_send_nack,
    input  logic       i_sda_in,
    input  logic       i_pop,
    output logic       o_empty,
    output t_item      o_item
);

    t_item cls_item;
    logic [$bits(t_item)-1:0] q_data;

    // Classify the word: codes without meaning become no command.
    always_comb begin
        cls_item.write_data = i_write_data;
        cls_item.send_nack  = i_send_nack;
        cls_item.sda_in     = i_sda_in;
        if (i_action inside {[3'd1:3'd5]}) begin
            cls_item.act = t_act'(i_action);
        end else begin
            cls_item.act = ACT_NONE;
        end
    end

    // Short queue toward the sequencer.
    i2cmb_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (MID_Q_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_item),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (q_data)
    );

    assign o_item = t_item'(q_data);

endmodule

@@ design/i2cmb_engine.sv @@
module i2cmb_engine
    import i2cmb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic        i_room,
    output logic        o_take,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_step, n_step;
    logic [15:0] r_ticks, n_ticks;
    logic [1:0]  r_units, n_units;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic        r_nack, n_nack;
    logic        r_ack, n_ack;
    logic [7:0]  r_rd, n_rd;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drv, n_drv;
    logic [15:0] r_unit_ticks;
    logic [15:0] ut;
    logic [15:0] tick_inc;
    logic        busy;
    logic        done;

    assign o_take   = i_valid && i_room;
    assign ut       = (r_unit_ticks == '0) ? 16'd1 : r_unit_ticks;
    assign tick_inc = r_ticks + 16'd1;

    // One tick of the pin sequencer.
    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_ticks = r_ticks;
        n_units = r_units;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_nack  = r_nack;
        n_ack   = r_ack;
        n_rd    = r_rd;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        done    = 1'b0;

        // Finish a sequence, or start a new command while idle.
        if (r_phase == PH_FIN || r_phase == PH_FIN0) begin
            if (r_phase == PH_FIN0) begin
                n_scl = 1'b0;
            end
            n_phase = PH_IDLE;
            done    = 1'b1;
        end else if (r_phase == PH_IDLE) begin
            case (i_item.act)
                ACT_START: begin
                    n_phase = PH_START;
                    n_step = 2'd0; n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                    n_units = 2'd2; n_ticks = '0;
                end
                ACT_STOP: begin
                    n_phase = PH_STOP;
                    n_step = 2'd0; n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                    n_units = 2'd2; n_ticks = '0;
                end
                ACT_WRITE: begin
                    n_phase = PH_WBIT;
                    n_shift = i_item.write_data;
                    n_bits  = '0;
                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b1;
                    n_units = 2'd1; n_ticks = '0;
                end
                ACT_READ: begin
                    n_phase = PH_RBIT;
                    n_nack  = i_item.send_nack;
                    n_shift = '0;
                    n_bits  = '0;
                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b0;
                    n_units = 2'd2; n_ticks = '0;
                end
                ACT_CLEAR: begin
                    n_phase = PH_CLK9;
                    n_bits  = '0;
                    n_step = 2'd0; n_scl = 1'b0; n_sda = 1'b1; n_drv = 1'b1;
                    n_units = 2'd2; n_ticks = '0;
                end
                default: begin
                end
            endcase
        end

        busy = (n_phase != PH_IDLE);

        // Result pins are those after the command decision.
        o_res.scl_level = n_scl;
        o_res.sda_level = n_sda;
        o_res.sda_drive = n_drv;
        o_res.busy_res  = busy;
        o_res.done_res  = done;

        // Hold timer and segment advance.
        if (busy) begin
            if (tick_inc >= ut) begin
                n_ticks = '0;
                if (n_units != '0) begin
                    n_units = n_units - 2'd1;
                end
                if (n_units == '0) begin
                    case (n_phase)
                        PH_START: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else begin
                                n_phase = PH_FIN;
                            end
                        end
                        PH_STOP: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else begin
                                n_phase = PH_FIN;
                            end
                        end
                        PH_WBIT: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b0; n_sda = n_shift[7];
                                n_drv = 1'b1; n_units = 2'd1;
                                n_shift = {n_shift[6:0], 1'b0};
                            end else if (n_step == 2'd1) begin
                                n_step = 2'd2; n_scl = 1'b1; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else begin
                                n_bits = n_bits + 4'd1;
                                if (n_bits < BYTE_BITS) begin
                                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b1;
                                    n_units = 2'd1;
                                end else begin
                                    n_phase = PH_WACK;
                                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b0;
                                    n_units = 2'd2;
                                end
                            end
                        end
                        PH_WACK: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b1; n_drv = 1'b0;
                                n_units = 2'd2;
                            end else begin
                                n_ack   = i_item.sda_in;
                                n_phase = PH_FIN0;
                            end
                        end
                        PH_RBIT: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b1; n_drv = 1'b0;
                                n_units = 2'd2;
                            end else begin
                                n_shift = {n_shift[6:0], i_item.sda_in};
                                n_bits  = n_bits + 4'd1;
                                if (n_bits < BYTE_BITS) begin
                                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b0;
                                    n_units = 2'd2;
                                end else begin
                                    n_rd    = n_shift;
                                    n_phase = PH_RACK;
                                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b1;
                                    n_units = 2'd1;
                                end
                            end
                        end
                        PH_RACK: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b0; n_sda = n_nack;
                                n_drv = 1'b1; n_units = 2'd1;
                            end else if (n_step == 2'd1) begin
                                n_step = 2'd2; n_scl = 1'b1; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else begin
                                n_phase = PH_FIN0;
                            end
                        end
                        PH_CLK9: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b1; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else begin
                                n_bits = n_bits + 4'd1;
                                if (n_bits < CLEAR_CLKS) begin
                                    n_step = 2'd0; n_scl = 1'b0; n_drv = 1'b1;
                                    n_units = 2'd2;
                                end else begin
                                    n_phase = PH_CLRSS;
                                    n_step = 2'd0; n_scl = 1'b1; n_sda = 1'b1;
                                    n_drv = 1'b1; n_units = 2'd2;
                                end
                            end
                        end
                        PH_CLRSS: begin
                            if (n_step == 2'd0) begin
                                n_step = 2'd1; n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else if (n_step == 2'd1) begin
                                n_step = 2'd2; n_scl = 1'b1; n_sda = 1'b0; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else if (n_step == 2'd2) begin
                                n_step = 2'd3; n_scl = 1'b1; n_sda = 1'b1; n_drv = 1'b1;
                                n_units = 2'd2;
                            end else begin
                                n_phase = PH_FIN;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end else begin
                n_ticks = tick_inc;
            end
        end

        // Data outputs show the registers after this tick.
        o_res.read_data = n_rd;
        o_res.ack_seen  = n_ack;
    end

    // Sequencer state advances only on a word taken from the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_ticks <= '0;
            r_units <= '0;
            r_bits  <= '0;
            r_shift <= '0;
            r_nack  <= 1'b0;
            r_ack   <= 1'b0;
            r_rd    <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_ticks <= n_ticks;
            r_units <= n_units;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_nack  <= n_nack;
            r_ack   <= n_ack;
            r_rd    <= n_rd;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_unit_ticks <= i_cfg_data;
        end
    end

endmodule

@@ design/i2c_master_bit_engine_core.sv @@
// Channel   Direction  Handshake         Word
// input     in         push / full       action, write_data, send_nack, sda_in
// result    out        empty / pop       scl, sda, drive, busy, done, read_data, ack
// config    in         i_cfg_we          unit_ticks (16 bit)
//
// One word is accepted per cycle unless full; the sequencer handles one word per
// cycle while the result queue has room. A result word is visible once its input
// word has passed the input queue, then the sequencer into the result queue.
// Reset is synchronous: sequencer idle, pins high and driven, unit_ticks 125.
// When pop stays low the result queue fills, the sequencer holds, the input
// queue fills and full rises; nothing is lost or repeated.
module i2c_master_bit_engine_core
    import i2cmb_pkg::*;
#(
    parameter int MID_Q_DEPTH = MID_DEPTH,
    parameter int OUT_Q_DEPTH = OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_write_data,
    input  logic        i_send_nack,
    input  logic        i_sda_in,
    output logic        empty,
    input  logic        pop,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_ack_seen
);

    t_item   mid_item;
    logic    mid_empty;
    logic    take;
    logic    out_full;
    t_result eng_res;
    t_result out_res;
    logic [$bits(t_result)-1:0] out_data;

    // Front: classify and queue input words.
    i2cmb_front #(
        .MID_Q_DEPTH (MID_Q_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_write_data (i_write_data),
        .i_send_nack  (i_send_nack),
        .i_sda_in     (i_sda_in),
        .i_pop        (take),
        .o_empty      (mid_empty),
        .o_item       (mid_item)
    );

    // Back: pin sequencer.
    i2cmb_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (!mid_empty),
        .i_item     (mid_item),
        .i_room     (!out_full),
        .o_take     (take),
        .o_res      (eng_res)
    );

    // Result queue.
    i2cmb_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (eng_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_data)
    );

    assign out_res     = t_result'(out_data);
    assign o_scl_level = out_res.scl_level;
    assign o_sda_level = out_res.sda_level;
    assign o_sda_drive = out_res.sda_drive;
    assign o_busy_res  = out_res.busy_res;
    assign o_done_res  = out_res.done_res;
    assign o_read_data = out_res.read_data;
    assign o_ack_seen  = out_res.ack_seen;

    // A finishing tick never reports busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_done_res) |-> !o_busy_res)
        else $error("done reported together with busy");

    // An accepted word reaches the middle queue.
    a_mid_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !mid_empty)
        else $error("accepted word missing from middle queue");

    // A word taken by the sequencer yields a waiting result.
    a_result_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!mid_empty && !out_full) |=> !empty)
        else $error("sequencer took a word without a result");

endmodule

@@ bench/i2c_pin_sequence_checker.sv @@
`timescale 1ns / 1ps
module i2c_pin_sequence_checker
    import i2cmb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_write_data,
    input  logic        i_send_nack,
    input  logic        i_sda_in,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_scl_level,
    input  logic        i_sda_level,
    input  logic        i_sda_drive,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [7:0]  i_read_data,
    input  logic        i_ack_seen,
    output int          o_fail_count,
    output int          o_words_waiting,
    output int          o_words_checked,
    output int          o_sequences_done
);

    localparam int REPORT_LIMIT = 10;

    // Our own copy of the pin sequencer state.
    t_phase      seq_phase;
    logic [2:0]  seg_step;
    logic [16:0] seg_ticks;
    logic [1:0]  seg_units;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift_reg;
    logic        nack_sel;
    logic        ack_reg;
    logic [7:0]  read_reg;
    logic        pin_scl;
    logic        pin_sda;
    logic        pin_drv;
    logic [15:0] unit_ticks;

    // Predicted result words, oldest first.
    t_result     pin_words[$];
    int          fail_cnt    = 0;
    int          checked_cnt = 0;
    int          done_cnt    = 0;

    task automatic clear_sequencer();
        unit_ticks = UNIT_TICKS_RESET;
        seq_phase  = PH_IDLE;
        seg_step   = '0;
        seg_ticks  = '0;
        seg_units  = '0;
        bit_cnt    = '0;
        shift_reg  = '0;
        nack_sel   = 1'b0;
        ack_reg    = 1'b0;
        read_reg   = '0;
        pin_scl    = 1'b1;
        pin_sda    = 1'b1;
        pin_drv    = 1'b1;
    endtask

    // Enter a new pin segment held for the given number of hold units.
    task automatic load_segment(input logic [2:0] step, input logic scl, input logic sda,
                                input logic drv, input logic [1:0] units);
        seg_step  = step;
        pin_scl   = scl;
        pin_sda   = sda;
        pin_drv   = drv;
        seg_units = units;
        seg_ticks = '0;
    endtask

    // Only called while idle; anything but a known command is ignored.
    task automatic start_command(input logic [2:0] act, input logic [7:0] wdata,
                                 input logic nack);
        case (act)
            ACT_START: begin
                seq_phase = PH_START;
                load_segment(3'd0, 1'b1, 1'b1, 1'b1, 2'd2);
            end
            ACT_STOP: begin
                seq_phase = PH_STOP;
                load_segment(3'd0, 1'b1, 1'b0, 1'b1, 2'd2);
            end
            ACT_WRITE: begin
                seq_phase = PH_WBIT;
                shift_reg = wdata;
                bit_cnt   = '0;
                load_segment(3'd0, 1'b0, pin_sda, 1'b1, 2'd1);
            end
            ACT_READ: begin
                seq_phase = PH_RBIT;
                nack_sel  = nack;
                shift_reg = '0;
                bit_cnt   = '0;
                load_segment(3'd0, 1'b0, pin_sda, 1'b0, 2'd2);
            end
            ACT_CLEAR: begin
                seq_phase = PH_CLK9;
                bit_cnt   = '0;
                load_segment(3'd0, 1'b0, 1'b1, 1'b1, 2'd2);
            end
            default: begin
            end
        endcase
    endtask

    // Move on once the current segment has used up all its hold units.
    task automatic finish_segment(input logic sda_in);
        case (seq_phase)
            PH_START: begin
                if (seg_step == 3'd0) load_segment(3'd1, 1'b1, 1'b0, 1'b1, 2'd2);
                else seq_phase = PH_FIN;
            end
            PH_STOP: begin
                if (seg_step == 3'd0) load_segment(3'd1, 1'b1, 1'b1, 1'b1, 2'd2);
                else seq_phase = PH_FIN;
            end
            PH_WBIT: begin
                if (seg_step == 3'd0) begin
                    load_segment(3'd1, 1'b0, shift_reg[7], 1'b1, 2'd1);
                    shift_reg = {shift_reg[6:0], 1'b0};
                end else if (seg_step == 3'd1) begin
                    load_segment(3'd2, 1'b1, pin_sda, 1'b1, 2'd2);
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BYTE_BITS) begin
                        load_segment(3'd0, 1'b0, pin_sda, 1'b1, 2'd1);
                    end else begin
                        seq_phase = PH_WACK;
                        load_segment(3'd0, 1'b0, pin_sda, 1'b0, 2'd2);
                    end
                end
            end
            PH_WACK: begin
                if (seg_step == 3'd0) begin
                    load_segment(3'd1, 1'b1, pin_sda, 1'b0, 2'd2);
                end else begin
                    ack_reg   = sda_in;
                    seq_phase = PH_FIN0;
                end
            end
            PH_RBIT: begin
                if (seg_step == 3'd0) begin
                    load_segment(3'd1, 1'b1, pin_sda, 1'b0, 2'd2);
                end else begin
                    shift_reg = {shift_reg[6:0], sda_in};
                    bit_cnt   = bit_cnt + 4'd1;
                    if (bit_cnt < BYTE_BITS) begin
                        load_segment(3'd0, 1'b0, pin_sda, 1'b0, 2'd2);
                    end else begin
                        read_reg  = shift_reg;
                        seq_phase = PH_RACK;
                        load_segment(3'd0, 1'b0, pin_sda, 1'b1, 2'd1);
                    end
                end
            end
            PH_RACK: begin
                if (seg_step == 3'd0) load_segment(3'd1, 1'b0, nack_sel, 1'b1, 2'd1);
                else if (seg_step == 3'd1) load_segment(3'd2, 1'b1, pin_sda, 1'b1, 2'd2);
                else seq_phase = PH_FIN0;
            end
            PH_CLK9: begin
                if (seg_step == 3'd0) begin
                    load_segment(3'd1, 1'b1, pin_sda, 1'b1, 2'd2);
                end else begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < CLEAR_CLKS) begin
                        load_segment(3'd0, 1'b0, pin_sda, 1'b1, 2'd2);
                    end else begin
                        seq_phase = PH_CLRSS;
                        load_segment(3'd0, 1'b1, 1'b1, 1'b1, 2'd2);
                    end
                end
            end
            PH_CLRSS: begin
                if (seg_step == 3'd0) load_segment(3'd1, 1'b1, 1'b0, 1'b1, 2'd2);
                else if (seg_step == 3'd1) load_segment(3'd2, 1'b1, 1'b0, 1'b1, 2'd2);
                else if (seg_step == 3'd2) load_segment(3'd3, 1'b1, 1'b1, 1'b1, 2'd2);
                else seq_phase = PH_FIN;
            end
            default: begin
                seq_phase = PH_IDLE;
            end
        endcase
    endtask

    // One tick of the sequencer: the pins seen this tick, then the tick count.
    task automatic predict_tick(input logic [2:0] act, input logic [7:0] wdata,
                                input logic nack, input logic sda_in,
                                output t_result word);
        logic [16:0] unit_len;
        logic        finished;
        finished = 1'b0;
        unit_len = (unit_ticks == 16'd0) ? 17'd1 : {1'b0, unit_ticks};
        if (seq_phase == PH_FIN || seq_phase == PH_FIN0) begin
            if (seq_phase == PH_FIN0) pin_scl = 1'b0;
            seq_phase = PH_IDLE;
            finished  = 1'b1;
        end else if (seq_phase == PH_IDLE) begin
            start_command(act, wdata, nack);
        end
        word.scl_level = pin_scl;
        word.sda_level = pin_sda;
        word.sda_drive = pin_drv;
        word.busy_res  = (seq_phase != PH_IDLE);
        word.done_res  = finished;
        if (word.busy_res) begin
            seg_ticks = seg_ticks + 17'd1;
            if (seg_ticks >= unit_len) begin
                seg_ticks = '0;
                if (seg_units != 2'd0) seg_units = seg_units - 2'd1;
                if (seg_units == 2'd0) finish_segment(sda_in);
            end
        end
        word.read_data = read_reg;
        word.ack_seen  = ack_reg;
    endtask

    function automatic string word_text(t_result w);
        return $sformatf("scl=%b sda=%b drv=%b busy=%b done=%b rd=%02h ack=%b",
                         w.scl_level, w.sda_level, w.sda_drive, w.busy_res,
                         w.done_res, w.read_data, w.ack_seen);
    endfunction

    // Check the popped word first, then the config write, then the pushed word.
    always @(posedge i_clk) begin
        t_result seen_word;
        t_result want_word;
        if (!i_rst_n) begin
            clear_sequencer();
            pin_words.delete();
        end else begin
            if (i_pop && !i_empty) begin
                seen_word = {i_scl_level, i_sda_level, i_sda_drive, i_busy_res,
                             i_done_res, i_read_data, i_ack_seen};
                if (pin_words.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT) begin
                        $display("Result word with no prediction waiting: %s",
                                 word_text(seen_word));
                    end
                end else begin
                    want_word = pin_words.pop_front();
                    checked_cnt++;
                    if (want_word.done_res) done_cnt++;
                    if (seen_word !== want_word) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_LIMIT) begin
                            $display("Result word %0d differs at %0t", checked_cnt, $realtime);
                            $display("    expected %s", word_text(want_word));
                            $display("    actual   %s", word_text(seen_word));
                        end
                    end
                end
            end
            if (i_cfg_we) unit_ticks = i_cfg_data;
            if (i_push && !i_full) begin
                predict_tick(i_action, i_write_data, i_send_nack, i_sda_in, want_word);
                pin_words.push_back(want_word);
            end
        end
        o_fail_count     <= fail_cnt;
        o_words_waiting  <= pin_words.size();
        o_words_checked  <= checked_cnt;
        o_sequences_done <= done_cnt;
    end

endmodule

@@ bench/i2c_master_bit_engine_core_tb.sv @@
`timescale 1ns / 1ps
module i2c_master_bit_engine_core_tb
    import i2cmb_pkg::*;
;

    localparam int WORD_TARGET = 600;
    localparam int PHASE_COUNT = 3;

    // How the SDA input is driven during a command.
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    // Kinds of random traffic.
    localparam int KIND_FRAME = 0;
    localparam int KIND_CLEAR = 1;
    localparam int KIND_LONE  = 2;
    localparam int KIND_NOISE = 3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [15:0] i_cfg_data   = '0;
    logic        push         = 1'b0;
    logic        full;
    logic [2:0]  i_action     = ACT_NONE;
    logic [7:0]  i_write_data = '0;
    logic        i_send_nack  = 1'b0;
    logic        i_sda_in     = 1'b1;
    logic        empty;
    logic        pop          = 1'b0;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_data;
    logic        o_ack_seen;

    int          fail_count;
    int          words_waiting;
    int          words_checked;
    int          sequences_done;
    int          words_sent     = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    logic [15:0] cur_unit_ticks = UNIT_TICKS_RESET;

    i2c_master_bit_engine_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_write_data (i_write_data),
        .i_send_nack  (i_send_nack),
        .i_sda_in     (i_sda_in),
        .empty        (empty),
        .pop          (pop),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_data  (o_read_data),
        .o_ack_seen   (o_ack_seen)
    );

    i2c_pin_sequence_checker seq_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_push           (push),
        .i_full           (full),
        .i_action         (i_action),
        .i_write_data     (i_write_data),
        .i_send_nack      (i_send_nack),
        .i_sda_in         (i_sda_in),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_scl_level      (o_scl_level),
        .i_sda_level      (o_sda_level),
        .i_sda_drive      (o_sda_drive),
        .i_busy_res       (o_busy_res),
        .i_done_res       (o_done_res),
        .i_read_data      (o_read_data),
        .i_ack_seen       (o_ack_seen),
        .o_fail_count     (fail_count),
        .o_words_waiting  (words_waiting),
        .o_words_checked  (words_checked),
        .o_sequences_done (sequences_done)
    );

    // 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side stalls at random.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hold units that one command spends from its first tick to its last.
    function automatic int command_units(logic [2:0] act);
        case (act)
            ACT_START, ACT_STOP: return 4;
            ACT_WRITE, ACT_READ: return 4 * BYTE_BITS + 4;
            ACT_CLEAR:           return 4 * CLEAR_CLKS + 8;
            default:             return 0;
        endcase
    endfunction

    function automatic int hold_ticks();
        return (cur_unit_ticks == 16'd0) ? 1 : int'(cur_unit_ticks);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_line_mode();
        case ($urandom_range(0, 3))
            0:       return SDA_LOW;
            1:       return SDA_HIGH;
            default: return SDA_RANDOM;
        endcase
    endfunction

    // Push one tick word, with random sender gaps, and wait until it is taken.
    task automatic send_word(input logic [2:0] act, input logic [7:0] wdata,
                             input logic nack, input logic sda);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_action     <= act;
        i_write_data <= wdata;
        i_send_nack  <= nack;
        i_sda_in     <= sda;
        do begin
            @(posedge i_clk);
        end while (full !== 1'b0);
        words_sent++;
    endtask

    // Plain ticks; with noise on, a few carry commands that a busy block ignores.
    task automatic feed_ticks(input int count, input int line_mode, input bit noisy);
        logic [2:0] act;
        logic       sda;
        for (int k = 0; k < count; k++) begin
            act = ACT_NONE;
            if (noisy && $urandom_range(0, 9) == 0) act = 3'($urandom_range(0, 7));
            case (line_mode)
                SDA_LOW:  sda = 1'b0;
                SDA_HIGH: sda = 1'b1;
                default:  sda = 1'($urandom_range(0, 1));
            endcase
            send_word(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda);
        end
    endtask

    // Issue a command on an idle tick and tick it through to its finishing tick.
    task automatic run_command(input logic [2:0] act, input logic [7:0] wdata,
                               input logic nack, input int line_mode);
        send_word(act, wdata, nack, 1'($urandom_range(0, 1)));
        feed_ticks(command_units(act) * hold_ticks(), line_mode, 1'b1);
    endtask

    // Hold the sender until every predicted word has been popped.
    task automatic drain();
        push <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (words_waiting != 0);
    endtask

    task automatic set_unit_ticks(input logic [15:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_unit_ticks = value;
    endtask

    task automatic random_traffic(input int kind);
        int         n_data;
        logic       nack;
        logic [2:0] act;
        case (kind)
            KIND_FRAME: begin
                // Start, address byte, one or two data bytes, stop.
                run_command(ACT_START, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM);
                run_command(ACT_WRITE, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM);
                n_data = $urandom_range(1, 2);
                for (int k = 0; k < n_data; k++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        nack = (k == n_data - 1);
                        if ($urandom_range(0, 7) == 0) nack = ~nack;
                        run_command(ACT_READ, pick_byte(), nack, pick_line_mode());
                    end else begin
                        run_command(ACT_WRITE, pick_byte(), 1'($urandom_range(0, 1)),
                                    pick_line_mode());
                    end
                end
                run_command(ACT_STOP, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM);
            end
            KIND_CLEAR: begin
                run_command(ACT_CLEAR, pick_byte(), 1'($urandom_range(0, 1)), SDA_RANDOM);
            end
            KIND_LONE: begin
                // A single command, often out of protocol order.
                act = 3'($urandom_range(ACT_START, ACT_CLEAR));
                run_command(act, pick_byte(), 1'($urandom_range(0, 1)), pick_line_mode());
            end
            default: begin
                // Random words, then enough quiet ticks for any started command to end.
                n_data = $urandom_range(1, 4);
                for (int k = 0; k < n_data; k++) begin
                    send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                feed_ticks(command_units(ACT_CLEAR) * hold_ticks(), SDA_RANDOM, 1'b0);
            end
        endcase
    endtask

    function automatic int pick_kind();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return KIND_FRAME;
        if (roll == 6) return KIND_CLEAR;
        if (roll == 7) return KIND_LONE;
        return KIND_NOISE;
    endfunction

    // Stimulus and verdict.
    initial begin
        int target;
        int guard;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state with the default hold unit.
        feed_ticks(2, SDA_RANDOM, 1'b0);

        // Zero hold unit acts as one; commands while busy and on the finishing tick
        // are ignored, as are the two unused action codes.
        set_unit_ticks(16'd0);
        send_word(ACT_START, 8'h00, 1'b0, 1'b1);
        send_word(ACT_WRITE, 8'hFF, 1'b1, 1'b0);
        feed_ticks(2, SDA_RANDOM, 1'b0);
        send_word(ACT_STOP, 8'hA5, 1'b0, 1'b1);
        send_word(3'd6, 8'h5A, 1'b1, 1'b0);
        send_word(3'd7, 8'hFF, 1'b1, 1'b1);
        run_command(ACT_STOP, 8'h00, 1'b0, SDA_RANDOM);

        // Longest hold unit, then a shorter one written in the middle of the start.
        set_unit_ticks(16'hFFFF);
        send_word(ACT_START, 8'hFF, 1'b1, 1'b0);
        feed_ticks(6, SDA_RANDOM, 1'b1);
        set_unit_ticks(16'd1);
        feed_ticks(command_units(ACT_STOP) + 1, SDA_RANDOM, 1'b0);

        // Random traffic in three stall patterns.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 66;
                end
                1: begin
                    tx_idle_pct = 66;
                    rx_idle_pct = 37;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            set_unit_ticks(16'($urandom_range(1, 2)));
            target = words_sent + WORD_TARGET / PHASE_COUNT;
            if (p == 0) random_traffic(KIND_CLEAR);
            while (words_sent < target) begin
                if ($urandom_range(0, 5) == 0) set_unit_ticks(16'($urandom_range(0, 3)));
                random_traffic(pick_kind());
            end
        end

        // Let the last words come out, then a few more cycles for strays.
        push <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (words_waiting != 0 && guard < 100000);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d tick words, checked %0d result words, %0d command sequences ended.",
                 words_sent, words_checked, sequences_done);
        $display("Hold units from 0 to 65535 ticks were used, with push and pop stalls mixed.");
        if (words_waiting != 0) $display("%0d predicted words never came out", words_waiting);
        if (fail_count == 0 && words_waiting == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ i2c_master_bit_engine_core.f @@
design/i2cmb_pkg.sv
design/i2cmb_queue.sv
design/i2cmb_front.sv
design/i2cmb_engine.sv
design/i2c_master_bit_engine_core.sv
bench/i2c_pin_sequence_checker.sv
bench/i2c_master_bit_engine_core_tb.sv
